>>> src/assert_macros.svh
// Assertion macros used by the top level of the Kirsch edge block.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside of reset.
`define KET_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed: label");

// Condition that must never be true outside of reset.
`define KET_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen: label");

`else

`define KET_ASSERT(label, clk, rst_n, prop)
`define KET_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> src/ket_pkg.sv
// Shared types and constants of the Kirsch edge threshold block.
// No dependencies; every module of the block and the testbench import this package.
package ket_pkg;

  // Field widths.
  localparam int unsigned ChanW      = 8;
  localparam int unsigned LumW       = 18;
  localparam int unsigned LineW      = 2 * LumW;
  localparam int unsigned TriW       = LumW + 2;
  localparam int unsigned HalfW      = LumW + 2;
  localparam int unsigned SumW       = LumW + 3;
  localparam int unsigned EdgeW      = 23;
  localparam int unsigned ThrW       = 12;
  localparam int unsigned ThrScaledW = 22;
  localparam int unsigned DimW       = 11;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 12;

  // Luminance weights in thousandths, and the threshold scale.
  localparam int unsigned LumCoefR = 299;
  localparam int unsigned LumCoefG = 587;
  localparam int unsigned LumCoefB = 114;
  localparam int unsigned ThrScale = 1000;

  // Frame geometry.
  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;
  localparam int unsigned DimReset     = 1024;
  localparam int unsigned MinDim       = 3;

  // Compass ring and output queue.
  localparam int unsigned RingN      = 8;
  localparam int unsigned OutQDepth  = 10;

  // Input word.
  typedef struct packed {
    logic             kind;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } in_word_t;

  // Output word.
  typedef struct packed {
    logic white;
    logic last_of_frame;
  } out_word_t;

  // One result on its way through the edge datapath.
  typedef struct packed {
    logic                        use_edge;
    logic                        last;
    logic [LumW-1:0]             border;
    logic [RingN-1:0][LumW-1:0]  ring;
  } edge_job_t;

endpackage

>>> src/kirsch_edge_threshold.sv
// Kirsch compass edge detector with threshold: top level.
// Depends on ket_pkg, ket_linemem, ket_kirsch, ket_ofifo and assert_macros.svh.
//
// Pixels enter in raster order on in_*, one word per cycle while in_ready_o is high.
// A word of kind pixel carries red, green and blue; a word of kind drain
// carries no pixel and releases one pending border result. Results leave
// on the out_* channel, one bit white/black and a last_of_frame flag.
// Each pixel word produces the result of the pixel width+1 positions
// before it, so a frame's last results come out with the next frame or
// through drains.
// Throughput is one word per cycle while the output queue has room; the line
// store is read in the cycle a word is accepted and written back in the next
// one, which is the loop that sets that rate. A result passes the accept-stage
// registers and the ket_kirsch stages before it reaches the output queue.
// When the receiver stalls, results collect in a ten-entry output queue;
// input is refused once queued and in-flight results fill it, and
// words that give no result wait for it too.
// Reset clears the counters, the window and the queue; the line store
// needs no clearing pass. Writing width or height restarts the frame and
// drops pending results; no input word is taken in a configuration cycle.
module kirsch_edge_threshold #(
  parameter int unsigned MAX_WIDTH  = ket_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = ket_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ket_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ket_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ket_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ket_pkg::out_word_t            out_word_o
);
  import ket_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW   = WW + 1;
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CmpA = (WW > DimW) ? WW : DimW;
  localparam int unsigned CmpW = (CmpA > HW) ? CmpA : HW;
  localparam int unsigned WidthReset  = (MAX_WIDTH < DimReset) ? MAX_WIDTH : DimReset;
  localparam int unsigned HeightReset = (MAX_HEIGHT < DimReset) ? MAX_HEIGHT : DimReset;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = CfgIdxW'(0),
    CFG_WIDTH     = CfgIdxW'(1),
    CFG_HEIGHT    = CfgIdxW'(2)
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SRC_EDGE   = 2'd0,
    SRC_WINDOW = 2'd1,
    SRC_MID    = 2'd2,
    SRC_UPPER  = 2'd3
  } val_src_e;

  // Configuration registers.
  logic [ThrScaledW-1:0] thr_scaled_q;
  logic [WW-1:0]         width_q;
  logic [HW-1:0]         height_q;
  logic [CmpW-1:0]       cfg_dim;
  logic [WW-1:0]         width_clamp;
  logic [HW-1:0]         height_clamp;
  logic                  restart;

  // Stream position and pending results.
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] ocol_q, ocol_d;
  logic [RW-1:0] orow_q, orow_d;
  logic [PW-1:0] pend_q, pend_d;

  // Accept-stage decode.
  logic          in_acc;
  logic          is_drain;
  logic          space;
  logic          pend_full;
  logic          interior;
  logic          emit;
  logic          last;
  val_src_e      src;
  logic [WW-1:0] wm1;
  logic [HW-1:0] hm1;
  logic [AW-1:0] col_last;
  logic [RW-1:0] row_last;
  logic [LumW-1:0] lum;
  logic [WW:0]   dsum;
  logic [WW:0]   dwrap;
  logic [AW-1:0] mid_addr;
  logic [AW-1:0] up_addr;
  logic [AW-1:0] rd_addr;

  // Second stage: line store data present.
  logic          s1_vld_q;
  logic          s1_pix_q;
  logic          s1_emit_q;
  val_src_e      s1_src_q;
  logic          s1_last_q;
  logic [AW-1:0] s1_col_q;
  logic [LumW-1:0] s1_lum_q;
  logic [LineW-1:0] rd_data;
  logic [LumW-1:0] top;
  logic [LumW-1:0] mid;
  logic [LumW-1:0] win_q [6];
  logic          mem_we;

  // Edge datapath interface.
  edge_job_t job;
  logic      job_vld;
  logic      res_vld;
  out_word_t res;

  // Clamped dimensions from the write data.
  always_comb begin
    cfg_dim = CmpW'(cfg_data_i[DimW-1:0]);
    if (cfg_dim < CmpW'(MinDim)) begin
      width_clamp = WW'(MinDim);
    end else if (cfg_dim > CmpW'(MAX_WIDTH)) begin
      width_clamp = WW'(MAX_WIDTH);
    end else begin
      width_clamp = cfg_dim[WW-1:0];
    end
    if (cfg_dim < CmpW'(MinDim)) begin
      height_clamp = HW'(MinDim);
    end else if (cfg_dim > CmpW'(MAX_HEIGHT)) begin
      height_clamp = HW'(MAX_HEIGHT);
    end else begin
      height_clamp = cfg_dim[HW-1:0];
    end
  end

  assign restart = cfg_we_i && ((cfg_idx_i == CFG_WIDTH) || (cfg_idx_i == CFG_HEIGHT));

  // Configuration write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_scaled_q <= '0;
      width_q      <= WW'(WidthReset);
      height_q     <= HW'(HeightReset);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: thr_scaled_q <= ThrScaledW'(cfg_data_i[ThrW-1:0])
                                       * ThrScaledW'(ThrScale);
        CFG_WIDTH:     width_q      <= width_clamp;
        CFG_HEIGHT:    height_q     <= height_clamp;
        default:       ;
      endcase
    end
  end

  // Handshake and word decode.
  assign in_ready_o = space && !cfg_we_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_drain   = in_word_i.kind;

  assign wm1      = width_q - WW'(1);
  assign hm1      = height_q - HW'(1);
  assign col_last = wm1[AW-1:0];
  assign row_last = hm1[RW-1:0];

  assign pend_full = pend_q == (PW'(width_q) + PW'(1));
  assign interior  = (orow_q != '0) && (orow_q != row_last)
                  && (ocol_q != '0) && (ocol_q != col_last);
  assign last      = (orow_q == row_last) && (ocol_q == col_last);
  assign emit      = is_drain ? ((pend_q != '0) && !interior) : pend_full;

  always_comb begin
    if (is_drain) begin
      src = pend_full ? SRC_UPPER : SRC_MID;
    end else begin
      src = interior ? SRC_EDGE : SRC_WINDOW;
    end
  end

  // Luminance in thousandths.
  assign lum = LumW'(in_word_i.red)   * LumW'(LumCoefR)
             + LumW'(in_word_i.green) * LumW'(LumCoefG)
             + LumW'(in_word_i.blue)  * LumW'(LumCoefB);

  // Column of the oldest pending pixel, for drains.
  assign dsum     = (WW + 1)'(col_q) + (WW + 1)'(width_q) - (WW + 1)'(pend_q);
  assign dwrap    = (dsum >= (WW + 1)'(width_q)) ? dsum - (WW + 1)'(width_q) : dsum;
  assign mid_addr = dwrap[AW-1:0];
  assign up_addr  = (col_q == '0) ? col_last : col_q - AW'(1);
  assign rd_addr  = is_drain ? (pend_full ? up_addr : mid_addr) : col_q;

  // Next stream position and pending count.
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    ocol_d = ocol_q;
    orow_d = orow_q;
    pend_d = pend_q;
    if (in_acc) begin
      if (!is_drain) begin
        if (col_q == col_last) begin
          col_d = '0;
          row_d = (row_q == row_last) ? '0 : row_q + RW'(1);
        end else begin
          col_d = col_q + AW'(1);
        end
        if (!pend_full) begin
          pend_d = pend_q + PW'(1);
        end
      end else if (emit) begin
        pend_d = pend_q - PW'(1);
      end
      if (emit) begin
        if (ocol_q == col_last) begin
          ocol_d = '0;
          orow_d = (orow_q == row_last) ? '0 : orow_q + RW'(1);
        end else begin
          ocol_d = ocol_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      pend_q <= '0;
    end else if (restart) begin
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      pend_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
      pend_q <= pend_d;
    end
  end

  // Accept-stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pix_q  <= !is_drain;
    s1_emit_q <= emit;
    s1_src_q  <= src;
    s1_last_q <= last;
    s1_col_q  <= col_q;
    s1_lum_q  <= lum;
  end

  // Line store: upper row in the high half, middle row in the low half.
  ket_linemem #(
    .Depth (MAX_WIDTH)
  ) u_linemem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_we),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({mid, s1_lum_q}),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign top    = rd_data[LineW-1:LumW];
  assign mid    = rd_data[LumW-1:0];
  assign mem_we = s1_vld_q && s1_pix_q;

  // Window of the two previous columns, shifted by each pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (mem_we) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= top;
      win_q[1] <= mid;
      win_q[2] <= s1_lum_q;
    end
  end

  // Result job: neighbors in clockwise order around the center pixel.
  always_comb begin
    job.use_edge = s1_src_q == SRC_EDGE;
    job.last     = s1_last_q;
    job.ring[0]  = win_q[3];
    job.ring[1]  = win_q[0];
    job.ring[2]  = top;
    job.ring[3]  = mid;
    job.ring[4]  = s1_lum_q;
    job.ring[5]  = win_q[2];
    job.ring[6]  = win_q[5];
    job.ring[7]  = win_q[4];
    unique case (s1_src_q)
      SRC_WINDOW: job.border = win_q[1];
      SRC_MID:    job.border = mid;
      SRC_UPPER:  job.border = top;
      default:    job.border = win_q[1];
    endcase
  end

  assign job_vld = s1_vld_q && s1_emit_q;

  ket_kirsch u_kirsch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_vld_i    (job_vld),
    .job_i        (job),
    .thr_scaled_i (thr_scaled_q),
    .res_vld_o    (res_vld),
    .res_o        (res)
  );

  ket_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (in_acc && emit),
    .space_o     (space),
    .push_i      (res_vld),
    .push_word_i (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // Checks.
`include "assert_macros.svh"

  // A pixel never reads the column that the previous pixel is writing back.
  `KET_ASSERT_NEVER(a_pix_rw_overlap, clk_i, rst_ni, in_acc && !is_drain && mem_we && (rd_addr == s1_col_q))

  // No more than width+1 results are ever pending.
  `KET_ASSERT(a_pend_bound, clk_i, rst_ni, pend_q <= (PW'(width_q) + PW'(1)))

  // A dimension write leaves nothing pending.
  `KET_ASSERT(a_restart_clears, clk_i, rst_ni, restart |=> (pend_q == '0) && (col_q == '0))

endmodule

>>> src/ket_linemem.sv
// Line store of the Kirsch block: one word per column holding two rows.
// Depends on ket_pkg. Synchronous read with write forwarding.
module ket_linemem #(
  parameter int unsigned Depth = ket_pkg::MaxWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [$clog2(Depth)-1:0]          wr_addr_i,
  input  logic [ket_pkg::LineW-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0]          rd_addr_i,
  output logic [ket_pkg::LineW-1:0]         rd_data_o
);
  import ket_pkg::*;

  logic [LineW-1:0] mem_q [Depth];
  logic [LineW-1:0] rd_q;
  logic [LineW-1:0] byp_data_q;
  logic             byp_hit_q;

  // Storage write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read; the array returns old data on a same-address write.
  always_ff @(posedge clk_i) begin
    rd_q       <= mem_q[rd_addr_i];
    byp_data_q <= wr_data_i;
  end

  // Remember a read that collided with a write in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_hit_q <= 1'b0;
    end else begin
      byp_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_hit_q ? byp_data_q : rd_q;

endmodule

>>> src/ket_kirsch.sv
// Pipelined Kirsch compass datapath with the threshold compare at its end.
// Depends on ket_pkg. Six register stages from job to result.
module ket_kirsch (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             job_vld_i,
  input  ket_pkg::edge_job_t               job_i,
  input  logic [ket_pkg::ThrScaledW-1:0]   thr_scaled_i,
  output logic                             res_vld_o,
  output ket_pkg::out_word_t               res_o
);
  import ket_pkg::*;

  // Valid bits of the six stages.
  logic [5:0] vld_q;

  // Stage 1: captured job.
  edge_job_t k1_q;

  // Stage 2: three-neighbor sums and half sums.
  logic [RingN-1:0][TriW-1:0] k2_tri_q;
  logic [HalfW-1:0]           k2_half0_q;
  logic [HalfW-1:0]           k2_half1_q;
  logic                       k2_use_q;
  logic                       k2_last_q;
  logic [LumW-1:0]            k2_border_q;

  // Stage 3: total of the ring.
  logic [RingN-1:0][TriW-1:0] k3_tri_q;
  logic [SumW-1:0]            k3_all_q;
  logic                       k3_use_q;
  logic                       k3_last_q;
  logic [LumW-1:0]            k3_border_q;

  // Stage 4: magnitude of each compass direction.
  logic [RingN-1:0][EdgeW-1:0] k4_mag_q;
  logic                        k4_use_q;
  logic                        k4_last_q;
  logic [LumW-1:0]             k4_border_q;

  // Stage 5: first level of the maximum.
  logic [3:0][EdgeW-1:0] k5_max_q;
  logic                  k5_use_q;
  logic                  k5_last_q;
  logic [LumW-1:0]       k5_border_q;

  // Stage 6: final value of the pixel.
  logic [EdgeW-1:0] k6_val_q;
  logic             k6_last_q;

  // Combinational values between the stages.
  logic [RingN-1:0][TriW-1:0]  tri_d;
  logic [HalfW-1:0]            half0_d;
  logic [HalfW-1:0]            half1_d;
  logic [EdgeW-1:0]            all3_d;
  logic [RingN-1:0][EdgeW-1:0] mag_d;
  logic [3:0][EdgeW-1:0]       max4_d;
  logic [EdgeW-1:0]            max_a;
  logic [EdgeW-1:0]            max_b;
  logic [EdgeW-1:0]            max_ab;
  logic [EdgeW-1:0]            val_d;

  // Three consecutive neighbors for each rotation, and the two half rings.
  always_comb begin
    for (int i = 0; i < RingN; i++) begin
      tri_d[i] = TriW'(k1_q.ring[i]) + TriW'(k1_q.ring[(i + 1) % RingN])
               + TriW'(k1_q.ring[(i + 2) % RingN]);
    end
    half0_d = HalfW'(k1_q.ring[0]) + HalfW'(k1_q.ring[1])
            + HalfW'(k1_q.ring[2]) + HalfW'(k1_q.ring[3]);
    half1_d = HalfW'(k1_q.ring[4]) + HalfW'(k1_q.ring[5])
            + HalfW'(k1_q.ring[6]) + HalfW'(k1_q.ring[7]);
  end

  // |3*all - 8*tri| per direction.
  always_comb begin
    logic [EdgeW-1:0] tri8;
    tri8   = '0;
    all3_d = EdgeW'(k3_all_q) + {EdgeW'(k3_all_q), 1'b0}[EdgeW-1:0];
    for (int i = 0; i < RingN; i++) begin
      tri8     = {EdgeW'(k3_tri_q[i]), 3'b000}[EdgeW-1:0];
      mag_d[i] = (all3_d >= tri8) ? (all3_d - tri8) : (tri8 - all3_d);
    end
  end

  // Maximum over the eight directions in two stages.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      max4_d[i] = (k4_mag_q[2*i] > k4_mag_q[2*i+1]) ? k4_mag_q[2*i] : k4_mag_q[2*i+1];
    end
    max_a  = (k5_max_q[0] > k5_max_q[1]) ? k5_max_q[0] : k5_max_q[1];
    max_b  = (k5_max_q[2] > k5_max_q[3]) ? k5_max_q[2] : k5_max_q[3];
    max_ab = (max_a > max_b) ? max_a : max_b;
    val_d  = k5_use_q ? max_ab : EdgeW'(k5_border_q);
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], job_vld_i};
    end
  end

  // Payload registers of all stages.
  always_ff @(posedge clk_i) begin
    k1_q        <= job_i;

    k2_tri_q    <= tri_d;
    k2_half0_q  <= half0_d;
    k2_half1_q  <= half1_d;
    k2_use_q    <= k1_q.use_edge;
    k2_last_q   <= k1_q.last;
    k2_border_q <= k1_q.border;

    k3_tri_q    <= k2_tri_q;
    k3_all_q    <= SumW'(k2_half0_q) + SumW'(k2_half1_q);
    k3_use_q    <= k2_use_q;
    k3_last_q   <= k2_last_q;
    k3_border_q <= k2_border_q;

    k4_mag_q    <= mag_d;
    k4_use_q    <= k3_use_q;
    k4_last_q   <= k3_last_q;
    k4_border_q <= k3_border_q;

    k5_max_q    <= max4_d;
    k5_use_q    <= k4_use_q;
    k5_last_q   <= k4_last_q;
    k5_border_q <= k4_border_q;

    k6_val_q    <= val_d;
    k6_last_q   <= k5_last_q;
  end

  // Threshold compare on the final value.
  assign res_vld_o           = vld_q[5];
  assign res_o.white         = EdgeW'(thr_scaled_i) >= k6_val_q;
  assign res_o.last_of_frame = k6_last_q;

endmodule

>>> src/ket_ofifo.sv
// Output queue of the Kirsch block with credit accounting for words in flight.
// Depends on ket_pkg for the output word type and the queue depth.
module ket_ofifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  output logic               space_o,
  input  logic               push_i,
  input  ket_pkg::out_word_t push_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ket_pkg::out_word_t out_word_o
);
  import ket_pkg::*;

  localparam int unsigned PtrW = $clog2(OutQDepth);
  localparam int unsigned CntW = $clog2(OutQDepth + 1);

  out_word_t       mem_q [OutQDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] fill_q;
  logic [CntW-1:0] credit_q;
  logic            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = fill_q != '0;
  assign out_word_o  = mem_q[rd_ptr_q];
  assign space_o     = credit_q < CntW'(OutQDepth);

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  // Pointers, fill level and credits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      credit_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(OutQDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(OutQDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      fill_q   <= fill_q + CntW'(push_i) - CntW'(pop);
      credit_q <= credit_q + CntW'(take_i) - CntW'(pop);
    end
  end

endmodule

>>> test/kirsch_edge_threshold_tb.sv
// Self-checking testbench for the Kirsch edge threshold block.
// Depends on ket_pkg and the kirsch_edge_threshold top level; it reads no files.
`timescale 1ns / 100ps

module kirsch_edge_threshold_tb;
  import ket_pkg::*;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT    = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_UNUSED    = 2'd3;

  // Word kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam int unsigned LINE_DEPTH   = MaxWidthDef;
  localparam int unsigned QUIET_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_word_t            in_word_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_word_t           out_word_o;

  kirsch_edge_threshold dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // Clock with a 12 ns period.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Predicted block state: configuration, stream position, line stores, window.
  logic [ThrW-1:0] pred_thr     = '0;
  int unsigned     pred_width   = DimReset;
  int unsigned     pred_height  = DimReset;
  int unsigned     pred_col     = 0;
  int unsigned     pred_row     = 0;
  int unsigned     pred_emitted = 0;
  logic [LumW-1:0] upper_lum  [LINE_DEPTH];
  logic [LumW-1:0] middle_lum [LINE_DEPTH];
  logic [LumW-1:0] win_lum    [6];

  // Black/white verdicts still owed by the block, oldest first.
  out_word_t verdict_q[$];
  out_word_t verdict_head;

  int unsigned fault_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          rx_hold_req = 1'b0;
  int unsigned rx_hold_left = 0;

  // Pixel texture of the current frame.
  int unsigned tex_mode = 0;
  logic [7:0]  tex_lo   = '0;
  logic [7:0]  tex_hi   = '0;

  initial begin
    for (int i = 0; i < LINE_DEPTH; i++) begin
      upper_lum[i]  = '0;
      middle_lum[i] = '0;
    end
    for (int i = 0; i < 6; i++) win_lum[i] = '0;
  end

  function automatic int unsigned clamp_dim(input logic [DimW-1:0] v, input int unsigned hi);
    if (v < MinDim) return MinDim;
    if (v > hi) return hi;
    return v;
  endfunction

  // Results waiting inside the block, counted from the stream position.
  function automatic int unsigned pending_cnt();
    int unsigned frame;
    frame = pred_width * pred_height;
    return (pred_row * pred_width + pred_col + frame - pred_emitted) % frame;
  endfunction

  function automatic bit is_inner(input int unsigned q);
    int unsigned r;
    int unsigned c;
    r = q / pred_width;
    c = q % pred_width;
    return r >= 1 && r + 2 <= pred_height && c >= 1 && c + 2 <= pred_width;
  endfunction

  // Largest |3T - 5S| over the eight rotations, written as |3*all - 8*S|.
  function automatic int unsigned compass_strength(input logic [RingN-1:0][LumW-1:0] ring);
    int total;
    int best;
    int s;
    int y;
    total = 0;
    best  = 0;
    for (int i = 0; i < RingN; i++) total += int'(ring[i]);
    for (int i = 0; i < RingN; i++) begin
      s = int'(ring[i]) + int'(ring[(i + 1) % RingN]) + int'(ring[(i + 2) % RingN]);
      y = 3 * total - 8 * s;
      if (y < 0) y = -y;
      if (y > best) best = y;
    end
    return best;
  endfunction

  task automatic emit_verdict(input int unsigned strength);
    out_word_t   v;
    int unsigned frame;
    frame = pred_width * pred_height;
    v.white         = (pred_thr * ThrScale >= strength);
    v.last_of_frame = (pred_emitted + 1 == frame);
    pred_emitted    = (pred_emitted + 1) % frame;
    verdict_q.push_back(v);
  endtask

  // Advances the predicted state by one accepted word.
  task automatic predict_verdict(input in_word_t w);
    int unsigned pend;
    int unsigned lum;
    logic [LumW-1:0] top;
    logic [LumW-1:0] mid;
    logic [RingN-1:0][LumW-1:0] ring;
    pend = pending_cnt();
    if (w.kind == KIND_DRAIN) begin
      // A drain releases only a border result; an interior one must wait.
      if (pend != 0 && !is_inner(pred_emitted)) begin
        if (pend <= pred_width)
          emit_verdict(middle_lum[(pred_col + pred_width - pend) % pred_width]);
        else
          emit_verdict(upper_lum[(pred_col + pred_width - 1) % pred_width]);
      end
    end else begin
      lum = LumCoefR * w.red + LumCoefG * w.green + LumCoefB * w.blue;
      top = upper_lum[pred_col];
      mid = middle_lum[pred_col];
      if (pend == pred_width + 1) begin
        if (is_inner(pred_emitted)) begin
          // Neighbors in clockwise order around the center.
          ring[0] = win_lum[3];
          ring[1] = win_lum[0];
          ring[2] = top;
          ring[3] = mid;
          ring[4] = lum[LumW-1:0];
          ring[5] = win_lum[2];
          ring[6] = win_lum[5];
          ring[7] = win_lum[4];
          emit_verdict(compass_strength(ring));
        end else begin
          emit_verdict(win_lum[1]);
        end
      end
      win_lum[3] = win_lum[0];
      win_lum[4] = win_lum[1];
      win_lum[5] = win_lum[2];
      win_lum[0] = top;
      win_lum[1] = mid;
      win_lum[2] = lum[LumW-1:0];
      upper_lum[pred_col]  = mid;
      middle_lum[pred_col] = lum[LumW-1:0];
      pred_col++;
      if (pred_col >= pred_width) begin
        pred_col = 0;
        pred_row++;
        if (pred_row >= pred_height) pred_row = 0;
      end
    end
  endtask

  // One register write; the predictor follows at the same edge.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_THRESHOLD: pred_thr = data[ThrW-1:0];
      REG_WIDTH: begin
        pred_width   = clamp_dim(data[DimW-1:0], MaxWidthDef);
        pred_col     = 0;
        pred_row     = 0;
        pred_emitted = 0;
      end
      REG_HEIGHT: begin
        pred_height  = clamp_dim(data[DimW-1:0], MaxHeightDef);
        pred_col     = 0;
        pred_row     = 0;
        pred_emitted = 0;
      end
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one word, with random gaps ahead of it, and waits for acceptance.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_verdict(w);
  endtask

  // Lets the block run dry before the next configuration change.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  function automatic in_word_t pixel_of(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    in_word_t w;
    w.kind  = KIND_PIXEL;
    w.red   = r;
    w.green = g;
    w.blue  = b;
    return w;
  endfunction

  // Drains carry random channel values, which the block ignores.
  function automatic in_word_t drain_word();
    in_word_t w;
    w       = pixel_of(8'($urandom), 8'($urandom), 8'($urandom));
    w.kind  = KIND_DRAIN;
    return w;
  endfunction

  function automatic in_word_t pixel_word();
    logic [7:0] lvl;
    case (tex_mode)
      0: return pixel_of(8'($urandom), 8'($urandom), 8'($urandom));
      1: begin
        // Gray two-level picture: flat areas and sharp edges.
        lvl = $urandom_range(1) ? tex_hi : tex_lo;
        return pixel_of(lvl, lvl, lvl);
      end
      default: return pixel_of($urandom_range(1) ? tex_hi : tex_lo,
                               $urandom_range(1) ? tex_hi : tex_lo,
                               $urandom_range(1) ? tex_hi : tex_lo);
    endcase
  endfunction

  task automatic pick_texture();
    tex_mode = $urandom_range(2);
    tex_lo   = 8'($urandom);
    tex_hi   = 8'($urandom);
  endtask

  function automatic logic [CfgDataW-1:0] pick_threshold();
    if ($urandom_range(99) < 30) return CfgDataW'($urandom_range(255));
    return CfgDataW'($urandom);
  endfunction

  // Sends pixels with drains mixed in; most finished frames get flushed by drains.
  task automatic send_stream(input int unsigned n_pixels, input int unsigned drain_pct);
    int unsigned sent;
    sent = 0;
    while (sent < n_pixels) begin
      if (pred_col == 0 && pred_row == 0) pick_texture();
      if ($urandom_range(99) < drain_pct) begin
        send_word(drain_word());
      end else begin
        send_word(pixel_word());
        sent++;
        if (pred_col == 0 && pred_row == 0 && $urandom_range(99) < 70)
          repeat (pred_width + 2) send_word(drain_word());
      end
    end
  endtask

  // Two 3x3 frames by hand: extreme colors, drains on empty and interior
  // results, and the threshold boundary where strength equals threshold*1000.
  task automatic test_directed_frames();
    write_reg(REG_WIDTH, 12'd3);
    write_reg(REG_HEIGHT, 12'd3);
    // Threshold still at its reset value of zero.
    send_word(pixel_of(8'd0, 8'd0, 8'd0));
    send_word(pixel_of(8'd255, 8'd255, 8'd255));
    send_word(pixel_of(8'd255, 8'd0, 8'd0));
    send_word(pixel_of(8'd0, 8'd255, 8'd0));
    send_word(pixel_of(8'd0, 8'd0, 8'd255));
    send_word(pixel_of(8'd255, 8'd255, 8'd255));
    send_word(pixel_of(8'd0, 8'd0, 8'd0));
    send_word(pixel_of(8'd255, 8'd255, 8'd0));
    // Oldest pending result is the center pixel, so this drain does nothing.
    send_word(drain_word());
    send_word(pixel_of(8'd0, 8'd255, 8'd255));
    repeat (4) send_word(drain_word());
    // Nothing left pending.
    send_word(drain_word());
    wait_quiet();

    // Gray g has luminance g*1000: 127 and 128 pass, 129 fails.
    write_reg(REG_THRESHOLD, 12'd128);
    send_word(pixel_of(8'd127, 8'd127, 8'd127));
    send_word(pixel_of(8'd128, 8'd128, 8'd128));
    send_word(pixel_of(8'd129, 8'd129, 8'd129));
    repeat (5) send_word(pixel_of(8'd128, 8'd128, 8'd128));
    send_word(pixel_of(8'd129, 8'd129, 8'd129));
    repeat (4) send_word(drain_word());
    wait_quiet();
  endtask

  // Configuration for one random phase; the first ones hit the extremes.
  task automatic configure_phase(input int unsigned phase);
    int unsigned pick;
    pick = $urandom_range(99);
    case (phase)
      0: begin
        write_reg(REG_THRESHOLD, 12'd0);
        write_reg(REG_WIDTH, 12'd3);
        write_reg(REG_HEIGHT, 12'd3);
      end
      1: begin
        // Width and height below the minimum clamp up to three.
        write_reg(REG_THRESHOLD, 12'hFFF);
        write_reg(REG_WIDTH, 12'd0);
        write_reg(REG_HEIGHT, 12'd2);
        write_reg(REG_UNUSED, 12'hFFF);
      end
      default: begin
        write_reg(REG_THRESHOLD, pick_threshold());
        // A threshold-only change keeps the stream where it was.
        if (pick >= 20 && pick < 30) begin
          write_reg(REG_UNUSED, CfgDataW'($urandom));
        end else if (pick >= 30) begin
          write_reg(REG_WIDTH, CfgDataW'(($urandom_range(1) << 11) | $urandom_range(3, 12)));
          write_reg(REG_HEIGHT, CfgDataW'(($urandom_range(1) << 11) | $urandom_range(3, 9)));
        end
      end
    endcase
  endtask

  task automatic test_random_streams(input int unsigned first, input int unsigned count);
    for (int unsigned p = first; p < first + count; p++) begin
      configure_phase(p);
      send_stream($urandom_range(30, 70), 8);
      wait_quiet();
    end
  endtask

  // Height written above the maximum clamps to it.
  task automatic test_tall_frame();
    write_reg(REG_THRESHOLD, pick_threshold());
    write_reg(REG_WIDTH, 12'd3);
    write_reg(REG_HEIGHT, 12'h7FF);
    send_stream(120, 5);
    wait_quiet();
  endtask

  // Full line store width; results start after width+1 pixels.
  task automatic test_wide_frame();
    write_reg(REG_THRESHOLD, pick_threshold());
    write_reg(REG_WIDTH, 12'hFFF);
    write_reg(REG_HEIGHT, 12'd3);
    send_stream(1040, 2);
    repeat (40) send_word(drain_word());
    wait_quiet();
  endtask

  // The receiver holds off long enough for the output queue to fill.
  task automatic test_output_backpressure();
    write_reg(REG_THRESHOLD, pick_threshold());
    write_reg(REG_WIDTH, 12'd4);
    write_reg(REG_HEIGHT, 12'd4);
    rx_hold_req = 1'b1;
    send_stream(48, 0);
    repeat (6) send_word(drain_word());
    wait_quiet();
  endtask

  // Receiver: random stalls, or a long hold when one is requested.
  always @(posedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Each accepted output word is checked against the oldest verdict.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected output word: white %0b last_of_frame %0b",
               out_word_o.white, out_word_o.last_of_frame);
        fault_cnt++;
      end else begin
        verdict_head = verdict_q.pop_front();
        if (out_word_o.white !== verdict_head.white) begin
          $error("white: expected %0b, got %0b", verdict_head.white, out_word_o.white);
          fault_cnt++;
        end
        if (out_word_o.last_of_frame !== verdict_head.last_of_frame) begin
          $error("last_of_frame: expected %0b, got %0b",
                 verdict_head.last_of_frame, out_word_o.last_of_frame);
          fault_cnt++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 21;
    rx_idle_pct = 48;
    test_directed_frames();
    test_random_streams(0, 4);
    test_tall_frame();

    tx_idle_pct = 48;
    rx_idle_pct = 21;
    test_random_streams(4, 3);
    test_wide_frame();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_streams(7, 3);
    test_output_backpressure();

    if (fault_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/ket_pkg.sv
src/ket_linemem.sv
src/ket_kirsch.sv
src/ket_ofifo.sv
src/kirsch_edge_threshold.sv
test/kirsch_edge_threshold_tb.sv
